FILE: src/rbe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbe_pkg: shared constants, types and helpers of the rigid body step block
// Fixed point formats, register map, sine and cosine constants and the
// rounding, clamping and saturation helpers of the datapath.
// ----------------------------------------------------------------------------
package rbe_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int COST_WIDTH = 48;
   localparam int CSR_IDX_W  = 3;
   localparam int LATENCY    = 25;

   // register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TIME_STEP   = 3'd0,
      CSR_INV_MASS    = 3'd1,
      CSR_INV_INERTIA = 3'd2,
      CSR_GRAVITY     = 3'd3,
      CSR_HALF_ARM    = 3'd4,
      CSR_TARGET_X    = 3'd5,
      CSR_TARGET_Y    = 3'd6
   } csr_idx_type;

   // register reset values
   localparam logic [15:0]        RST_TIME_STEP = 16'd655;
   localparam logic [30:0]        RST_INV_MASS  = 31'd65536;
   localparam logic [30:0]        RST_INV_INER  = 31'd65536;
   localparam logic [30:0]        RST_GRAVITY   = 31'd131072;
   localparam logic [30:0]        RST_HALF_ARM  = 31'd327680;
   localparam logic signed [31:0] RST_TARGET    = 32'sd22937600;

   // angle to turn phase in Q0.32, pi and one in Q2.30
   localparam logic [29:0] TURN_PER_RAD = 30'd683565276;
   localparam logic [31:0] PI_Q30       = 32'd3373259426;
   localparam logic [30:0] ONE_Q30      = 31'h4000_0000;

   // reciprocals for exact floor division of values below 2^30
   localparam logic [30:0] RCP_42 = 31'(((64'd1 << 36) + 64'd41) / 64'd42);
   localparam logic [30:0] RCP_56 = 31'(((64'd1 << 36) + 64'd55) / 64'd56);
   localparam logic [30:0] RCP_20 = 31'(((64'd1 << 35) + 64'd19) / 64'd20);
   localparam logic [30:0] RCP_30 = 31'(((64'd1 << 35) + 64'd29) / 64'd30);
   localparam logic [30:0] RCP_6  = 31'(((64'd1 << 33) + 64'd5) / 64'd6);
   localparam logic [30:0] RCP_12 = 31'(((64'd1 << 34) + 64'd11) / 64'd12);

   localparam logic [96:0] PROD_LIM = 97'd1 << 61;

   // round a product magnitude half up at bit sh, clamp at 2^61
   function automatic logic [61:0] rnd_mag(input logic [95:0] p, input logic [4:0] sh);
      logic [96:0] r;
      r = ({1'b0, p} + (97'd1 << (sh - 5'd1))) >> sh;
      if (r > PROD_LIM) begin
         r = PROD_LIM;
      end
      return r[61:0];
   endfunction

   // turn sign and magnitude into a signed value
   function automatic logic signed [63:0] apply_sign(input logic [61:0] mag, input logic neg);
      logic signed [63:0] m;
      m = $signed({2'b00, mag});
      return neg ? -m : m;
   endfunction

   // saturate to the data range
   function automatic logic signed [31:0] sat_dw(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = 32'(v);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: src/rigid_body_euler_step_with_gradient.sv
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one item per cycle while busy is low; the pipeline of
// multiply stages has no backpressure, since the receiver takes every
// result in its strobe cycle. busy follows reset only. Reset empties
// the pipeline and loads the register defaults; datapath registers are
// not reset.
// ----------------------------------------------------------------------------
// rigid_body_euler_step_with_gradient
// One semi-implicit Euler step of a planar rigid body with the squared
// distance cost and the thrust gradient, in a 25 stage pipeline.
// ----------------------------------------------------------------------------
module rigid_body_euler_step_with_gradient
   import rbe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic signed [31:0]    req_pos_x,
   input  logic signed [31:0]    req_pos_y,
   input  logic signed [31:0]    req_vel_x,
   input  logic signed [31:0]    req_vel_y,
   input  logic signed [31:0]    req_angle,
   input  logic signed [31:0]    req_ang_vel,
   input  logic signed [31:0]    req_thrust_left,
   input  logic signed [31:0]    req_thrust_right,
   input  logic signed [31:0]    req_cost_seed,
   output logic                  rsp_valid,
   output logic signed [31:0]    rsp_new_pos_x,
   output logic signed [31:0]    rsp_new_pos_y,
   output logic signed [31:0]    rsp_new_vel_x,
   output logic signed [31:0]    rsp_new_vel_y,
   output logic signed [31:0]    rsp_new_angle,
   output logic signed [31:0]    rsp_new_ang_vel,
   output logic [COST_WIDTH-1:0] rsp_cost,
   output logic signed [31:0]    rsp_grad_left,
   output logic signed [31:0]    rsp_grad_right,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]           csr_wr_data
);

   // ------------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------------
   logic [15:0]        time_step_ff;
   logic [30:0]        inv_mass_ff;
   logic [30:0]        inv_inertia_ff;
   logic [30:0]        gravity_ff;
   logic [30:0]        half_arm_ff;
   logic signed [31:0] target_x_ff;
   logic signed [31:0] target_y_ff;

   // load on write, drop unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff   <= RST_TIME_STEP;
         inv_mass_ff    <= RST_INV_MASS;
         inv_inertia_ff <= RST_INV_INER;
         gravity_ff     <= RST_GRAVITY;
         half_arm_ff    <= RST_HALF_ARM;
         target_x_ff    <= RST_TARGET;
         target_y_ff    <= RST_TARGET;
      end else if (csr_wr_en) begin
         case (csr_idx_type'(csr_index))
            CSR_TIME_STEP:   time_step_ff   <= csr_wr_data[15:0];
            CSR_INV_MASS:    inv_mass_ff    <= csr_wr_data[30:0];
            CSR_INV_INERTIA: inv_inertia_ff <= csr_wr_data[30:0];
            CSR_GRAVITY:     gravity_ff     <= csr_wr_data[30:0];
            CSR_HALF_ARM:    half_arm_ff    <= csr_wr_data[30:0];
            CSR_TARGET_X:    target_x_ff    <= $signed(csr_wr_data);
            CSR_TARGET_Y:    target_y_ff    <= $signed(csr_wr_data);
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // valid bits
   // ------------------------------------------------------------------------
   logic [LATENCY:1] vld_ff;

   assign busy = reset;

   // advance valid with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LATENCY-1:1], start & ~busy};
      end
   end

   // ------------------------------------------------------------------------
   // delay lines, index is the stage that holds the value
   // ------------------------------------------------------------------------
   logic signed [31:0] px_ff   [1:16];
   logic signed [31:0] py_ff   [1:16];
   logic signed [31:0] vx_ff   [1:14];
   logic signed [31:0] vy_ff   [1:14];
   logic signed [31:0] th_ff   [1:6];
   logic signed [31:0] w_ff    [1:4];
   logic signed [31:0] seed_ff [1:17];
   logic [32:0]        netm_ff [1:10];
   logic               netn_ff [1:10];
   logic               difn_ff [1:4];
   logic [1:0]         quad_ff [2:9];
   logic               flip_ff [2:9];
   logic [29:0]        x_ff    [3:8];
   logic [29:0]        x2_ff   [4:8];
   logic signed [31:0] nw_ff   [5:25];
   logic signed [31:0] na_ff   [7:25];
   logic [30:0]        snm_ff  [10:22];
   logic               snn_ff  [10:22];
   logic [30:0]        csm_ff  [10:22];
   logic               csn_ff  [10:22];
   logic signed [31:0] nvx_ff  [15:25];
   logic signed [31:0] nvy_ff  [15:25];
   logic signed [31:0] npx_ff  [17:25];
   logic signed [31:0] npy_ff  [17:25];
   logic [47:0]        cost_ff [20:25];

   // ------------------------------------------------------------------------
   // stage 1: turn phase, net and differential thrust
   // ------------------------------------------------------------------------
   logic signed [62:0] ph_prod;
   logic signed [32:0] net_sum, dif_sum;
   logic [31:0]        ph_ff;
   logic [32:0]        difm_ff;

   always_comb begin
      ph_prod = $signed(req_angle) * $signed({1'b0, TURN_PER_RAD});
      net_sum = 33'(req_thrust_left) + 33'(req_thrust_right);
      dif_sum = 33'(req_thrust_right) - 33'(req_thrust_left);
   end

   always_ff @(posedge clock) begin
      ph_ff      <= ph_prod[47:16];
      netn_ff[1] <= net_sum[32];
      netm_ff[1] <= net_sum[32] ? 33'(-net_sum) : 33'(net_sum);
      difn_ff[1] <= dif_sum[32];
      difm_ff    <= dif_sum[32] ? 33'(-dif_sum) : 33'(dif_sum);
      px_ff[1]   <= req_pos_x;
      py_ff[1]   <= req_pos_y;
      vx_ff[1]   <= req_vel_x;
      vy_ff[1]   <= req_vel_y;
      th_ff[1]   <= req_angle;
      w_ff[1]    <= req_ang_vel;
      seed_ff[1] <= req_cost_seed;
   end

   // ------------------------------------------------------------------------
   // stage 2: fold the phase to an eighth turn, scale by pi; torque product
   // ------------------------------------------------------------------------
   logic [29:0] t_fold;
   logic [30:0] t_mirror;
   logic [1:0]  quad_in;
   logic        flip_in;
   logic [61:0] xp_ff;
   logic [63:0] c1p_ff;

   always_comb begin
      t_mirror = ONE_Q30 - {1'b0, ph_ff[29:0]};
      if (ph_ff[29]) begin
         t_fold  = t_mirror[29:0];
         flip_in = 1'b1;
         quad_in = ph_ff[31:30] + 2'd1;
      end else begin
         t_fold  = ph_ff[29:0];
         flip_in = 1'b0;
         quad_in = ph_ff[31:30];
      end
   end

   always_ff @(posedge clock) begin
      quad_ff[2] <= quad_in;
      flip_ff[2] <= flip_in;
      xp_ff      <= t_fold * PI_Q30;
      c1p_ff     <= 64'(difm_ff * half_arm_ff);
   end

   // ------------------------------------------------------------------------
   // stage 3: x and x squared; split torque times inverse inertia
   // ------------------------------------------------------------------------
   logic [61:0] xr;
   logic [29:0] x_in;
   logic [47:0] c1;
   logic [59:0] x2p_ff;
   logic [54:0] c2lo_ff, c2hi_ff;

   always_comb begin
      xr   = xp_ff + 62'h4000_0000;
      x_in = xr[60:31];
      c1   = 48'(rnd_mag(96'(c1p_ff), 5'd16));
   end

   always_ff @(posedge clock) begin
      x_ff[3] <= x_in;
      x2p_ff  <= x_in * x_in;
      c2lo_ff <= c1[23:0] * inv_inertia_ff;
      c2hi_ff <= c1[47:24] * inv_inertia_ff;
   end

   // ------------------------------------------------------------------------
   // stage 4: round x squared, first divisions; split scaling by dt
   // ------------------------------------------------------------------------
   logic [59:0] x2r;
   logic [29:0] x2_in;
   logic [61:0] c2;
   logic [60:0] qs1_ff, qc1_ff;
   logic [46:0] c3lo_ff, c3hi_ff;

   always_comb begin
      x2r   = x2p_ff + 60'h2000_0000;
      x2_in = x2r[59:30];
      c2    = rnd_mag(96'(c2lo_ff) + (96'(c2hi_ff) << 24), 5'd16);
   end

   always_ff @(posedge clock) begin
      x2_ff[4] <= x2_in;
      qs1_ff   <= x2_in * RCP_42;
      qc1_ff   <= x2_in * RCP_56;
      c3lo_ff  <= c2[30:0] * time_step_ff;
      c3hi_ff  <= c2[61:31] * time_step_ff;
   end

   // ------------------------------------------------------------------------
   // stage 5: first polynomial terms; new angular velocity
   // ------------------------------------------------------------------------
   logic [30:0] ps1, pc1;
   logic [61:0] c3;
   logic [60:0] ms1_ff, mc1_ff;

   always_comb begin
      ps1 = ONE_Q30 - 31'(qs1_ff >> 36);
      pc1 = ONE_Q30 - 31'(qc1_ff >> 36);
      c3  = rnd_mag(96'(c3lo_ff) + (96'(c3hi_ff) << 31), 5'd16);
   end

   always_ff @(posedge clock) begin
      ms1_ff   <= x2_ff[4] * ps1;
      mc1_ff   <= x2_ff[4] * pc1;
      nw_ff[5] <= sat_dw(64'(w_ff[4]) + apply_sign(c3, difn_ff[4]));
   end

   // ------------------------------------------------------------------------
   // stage 6: second divisions; angle increment product
   // ------------------------------------------------------------------------
   logic [60:0] qs2_ff, qc2_ff;
   logic [31:0] nw_mag;
   logic [47:0] nap_ff;
   logic        nan_ff;

   always_comb begin
      nw_mag = nw_ff[5][31] ? 32'(-33'(nw_ff[5])) : 32'(nw_ff[5]);
   end

   always_ff @(posedge clock) begin
      qs2_ff <= ms1_ff[59:30] * RCP_20;
      qc2_ff <= mc1_ff[59:30] * RCP_30;
      nap_ff <= nw_mag * time_step_ff;
      nan_ff <= nw_ff[5][31];
   end

   // ------------------------------------------------------------------------
   // stage 7: second polynomial terms; new angle
   // ------------------------------------------------------------------------
   logic [30:0] ps2, pc2;
   logic [60:0] ms2_ff, mc2_ff;

   always_comb begin
      ps2 = ONE_Q30 - 31'(qs2_ff >> 35);
      pc2 = ONE_Q30 - 31'(qc2_ff >> 35);
   end

   always_ff @(posedge clock) begin
      ms2_ff   <= x2_ff[6] * ps2;
      mc2_ff   <= x2_ff[6] * pc2;
      na_ff[7] <= sat_dw(64'(th_ff[6])
                         + apply_sign(rnd_mag(96'(nap_ff), 5'd16), nan_ff));
   end

   // ------------------------------------------------------------------------
   // stage 8: third divisions
   // ------------------------------------------------------------------------
   logic [60:0] qs3_ff, qc3_ff;

   always_ff @(posedge clock) begin
      qs3_ff <= ms2_ff[59:30] * RCP_6;
      qc3_ff <= mc2_ff[59:30] * RCP_12;
   end

   // ------------------------------------------------------------------------
   // stage 9: last polynomial products
   // ------------------------------------------------------------------------
   logic [30:0] ps3, pc3;
   logic [60:0] sp_ff, cp_ff;

   always_comb begin
      ps3 = ONE_Q30 - 31'(qs3_ff >> 33);
      pc3 = ONE_Q30 - 31'(qc3_ff >> 34);
   end

   always_ff @(posedge clock) begin
      sp_ff <= x_ff[8] * ps3;
      cp_ff <= x2_ff[8] * pc3;
   end

   // ------------------------------------------------------------------------
   // stage 10: sine and cosine, placed by quadrant as sign and magnitude
   // ------------------------------------------------------------------------
   logic [30:0] s_mag, c_mag, snm_in, csm_in;
   logic        snn_in, csn_in;

   always_comb begin
      s_mag = {1'b0, sp_ff[59:30]};
      c_mag = ONE_Q30 - {2'b00, cp_ff[59:31]};
      case (quad_ff[9])
         2'd0: begin
            snm_in = s_mag; snn_in = flip_ff[9];
            csm_in = c_mag; csn_in = 1'b0;
         end
         2'd1: begin
            snm_in = c_mag; snn_in = 1'b0;
            csm_in = s_mag; csn_in = ~flip_ff[9];
         end
         2'd2: begin
            snm_in = s_mag; snn_in = ~flip_ff[9];
            csm_in = c_mag; csn_in = 1'b1;
         end
         default: begin
            snm_in = c_mag; snn_in = 1'b1;
            csm_in = s_mag; csn_in = flip_ff[9];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      snm_ff[10] <= snm_in;
      snn_ff[10] <= snn_in;
      csm_ff[10] <= csm_in;
      csn_ff[10] <= csn_in;
   end

   // ------------------------------------------------------------------------
   // stage 11: rotate the net thrust
   // ------------------------------------------------------------------------
   logic [63:0] fxp_ff, fyp_ff;
   logic        fxn_ff, fsn_ff;

   always_ff @(posedge clock) begin
      fxp_ff <= netm_ff[10] * csm_ff[10];
      fyp_ff <= netm_ff[10] * snm_ff[10];
      fxn_ff <= netn_ff[10] ^ csn_ff[10];
      fsn_ff <= netn_ff[10] ^ snn_ff[10];
   end

   // ------------------------------------------------------------------------
   // stage 12: round the forces, take off gravity
   // ------------------------------------------------------------------------
   logic [32:0]        fxm_ff;
   logic               fxn2_ff;
   logic signed [34:0] fy_ff;

   always_ff @(posedge clock) begin
      fxm_ff  <= 33'(rnd_mag(96'(fxp_ff), 5'd30));
      fxn2_ff <= fxn_ff;
      fy_ff   <= 35'(apply_sign(rnd_mag(96'(fyp_ff), 5'd30), fsn_ff))
                 - 35'(gravity_ff);
   end

   // ------------------------------------------------------------------------
   // stage 13: forces times inverse mass
   // ------------------------------------------------------------------------
   logic [32:0] fym;
   logic [63:0] a1px_ff, a1py_ff;
   logic        axn_ff, ayn_ff;

   always_comb begin
      fym = fy_ff[34] ? 33'(-fy_ff) : 33'(fy_ff);
   end

   always_ff @(posedge clock) begin
      a1px_ff <= fxm_ff * inv_mass_ff;
      a1py_ff <= fym * inv_mass_ff;
      axn_ff  <= fxn2_ff;
      ayn_ff  <= fy_ff[34];
   end

   // ------------------------------------------------------------------------
   // stage 14: accelerations times dt
   // ------------------------------------------------------------------------
   logic [47:0] a1x, a1y;
   logic [63:0] a2px_ff, a2py_ff;
   logic        axn2_ff, ayn2_ff;

   always_comb begin
      a1x = 48'(rnd_mag(96'(a1px_ff), 5'd16));
      a1y = 48'(rnd_mag(96'(a1py_ff), 5'd16));
   end

   always_ff @(posedge clock) begin
      a2px_ff <= a1x * time_step_ff;
      a2py_ff <= a1y * time_step_ff;
      axn2_ff <= axn_ff;
      ayn2_ff <= ayn_ff;
   end

   // ------------------------------------------------------------------------
   // stage 15: new velocities
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      nvx_ff[15] <= sat_dw(64'(vx_ff[14])
                           + apply_sign(rnd_mag(96'(a2px_ff), 5'd16), axn2_ff));
      nvy_ff[15] <= sat_dw(64'(vy_ff[14])
                           + apply_sign(rnd_mag(96'(a2py_ff), 5'd16), ayn2_ff));
   end

   // ------------------------------------------------------------------------
   // stage 16: velocities times dt
   // ------------------------------------------------------------------------
   logic [31:0] nvxm, nvym;
   logic [47:0] npxp_ff, npyp_ff;
   logic        pxn_ff, pyn_ff;

   always_comb begin
      nvxm = nvx_ff[15][31] ? 32'(-33'(nvx_ff[15])) : 32'(nvx_ff[15]);
      nvym = nvy_ff[15][31] ? 32'(-33'(nvy_ff[15])) : 32'(nvy_ff[15]);
   end

   always_ff @(posedge clock) begin
      npxp_ff <= nvxm * time_step_ff;
      npyp_ff <= nvym * time_step_ff;
      pxn_ff  <= nvx_ff[15][31];
      pyn_ff  <= nvy_ff[15][31];
   end

   // ------------------------------------------------------------------------
   // stage 17: new positions
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      npx_ff[17] <= sat_dw(64'(px_ff[16])
                           + apply_sign(rnd_mag(96'(npxp_ff), 5'd16), pxn_ff));
      npy_ff[17] <= sat_dw(64'(py_ff[16])
                           + apply_sign(rnd_mag(96'(npyp_ff), 5'd16), pyn_ff));
   end

   // ------------------------------------------------------------------------
   // stage 18: position errors, squares and seeded errors
   // ------------------------------------------------------------------------
   logic signed [32:0] exv, eyv, sdv;
   logic [31:0]        exm, eym, sdm;
   logic [63:0]        sqpx_ff, sqpy_ff;
   logic [64:0]        bpx_ff, bpy_ff;
   logic               bxn_ff, byn_ff;

   always_comb begin
      exv = 33'(npx_ff[17]) - 33'(target_x_ff);
      eyv = 33'(npy_ff[17]) - 33'(target_y_ff);
      sdv = 33'(seed_ff[17]);
      exm = exv[32] ? 32'(-exv) : 32'(exv);
      eym = eyv[32] ? 32'(-eyv) : 32'(eyv);
      sdm = sdv[32] ? 32'(-sdv) : 32'(sdv);
   end

   always_ff @(posedge clock) begin
      sqpx_ff <= exm * exm;
      sqpy_ff <= eym * eym;
      bpx_ff  <= {exm, 1'b0} * sdm;
      bpy_ff  <= {eym, 1'b0} * sdm;
      bxn_ff  <= exv[32] ^ sdv[32];
      byn_ff  <= eyv[32] ^ sdv[32];
   end

   // ------------------------------------------------------------------------
   // stage 19: round squares, first dt of the adjoint
   // ------------------------------------------------------------------------
   logic [48:0] b1x, b1y;
   logic [48:0] sqx_ff, sqy_ff;
   logic [64:0] b2px_ff, b2py_ff;
   logic        bxn2_ff, byn2_ff;

   always_comb begin
      b1x = 49'(rnd_mag(96'(bpx_ff), 5'd16));
      b1y = 49'(rnd_mag(96'(bpy_ff), 5'd16));
   end

   always_ff @(posedge clock) begin
      sqx_ff  <= 49'(rnd_mag(96'(sqpx_ff), 5'd16));
      sqy_ff  <= 49'(rnd_mag(96'(sqpy_ff), 5'd16));
      b2px_ff <= b1x * time_step_ff;
      b2py_ff <= b1y * time_step_ff;
      bxn2_ff <= bxn_ff;
      byn2_ff <= byn_ff;
   end

   // ------------------------------------------------------------------------
   // stage 20: cost; second dt of the adjoint
   // ------------------------------------------------------------------------
   logic [49:0] sq_sum;
   logic [48:0] b2x, b2y;
   logic [64:0] b3px_ff, b3py_ff;
   logic        bxn3_ff, byn3_ff;

   always_comb begin
      sq_sum = 50'(sqx_ff) + 50'(sqy_ff);
      b2x    = 49'(rnd_mag(96'(b2px_ff), 5'd16));
      b2y    = 49'(rnd_mag(96'(b2py_ff), 5'd16));
   end

   always_ff @(posedge clock) begin
      cost_ff[20] <= (sq_sum > 50'({COST_WIDTH{1'b1}})) ? {COST_WIDTH{1'b1}}
                                                        : sq_sum[47:0];
      b3px_ff     <= b2x * time_step_ff;
      b3py_ff     <= b2y * time_step_ff;
      bxn3_ff     <= bxn2_ff;
      byn3_ff     <= byn2_ff;
   end

   // ------------------------------------------------------------------------
   // stage 21: split adjoint times inverse mass
   // ------------------------------------------------------------------------
   logic [48:0] b3x, b3y;
   logic [54:0] dxlo_ff, dylo_ff;
   logic [55:0] dxhi_ff, dyhi_ff;
   logic        dxn_ff, dyn_ff;

   always_comb begin
      b3x = 49'(rnd_mag(96'(b3px_ff), 5'd16));
      b3y = 49'(rnd_mag(96'(b3py_ff), 5'd16));
   end

   always_ff @(posedge clock) begin
      dxlo_ff <= b3x[23:0] * inv_mass_ff;
      dxhi_ff <= b3x[48:24] * inv_mass_ff;
      dylo_ff <= b3y[23:0] * inv_mass_ff;
      dyhi_ff <= b3y[48:24] * inv_mass_ff;
      dxn_ff  <= bxn3_ff;
      dyn_ff  <= byn3_ff;
   end

   // ------------------------------------------------------------------------
   // stage 22: force adjoints
   // ------------------------------------------------------------------------
   logic [61:0] adjx_ff, adjy_ff;
   logic        dxn2_ff, dyn2_ff;

   always_ff @(posedge clock) begin
      adjx_ff <= rnd_mag(96'(dxlo_ff) + (96'(dxhi_ff) << 24), 5'd16);
      adjy_ff <= rnd_mag(96'(dylo_ff) + (96'(dyhi_ff) << 24), 5'd16);
      dxn2_ff <= dxn_ff;
      dyn2_ff <= dyn_ff;
   end

   // ------------------------------------------------------------------------
   // stage 23: split projection on cosine and sine of the old angle
   // ------------------------------------------------------------------------
   logic [61:0] gxlo_ff, gxhi_ff, gylo_ff, gyhi_ff;
   logic        gxn_ff, gyn_ff;

   always_ff @(posedge clock) begin
      gxlo_ff <= csm_ff[22] * adjx_ff[30:0];
      gxhi_ff <= csm_ff[22] * adjx_ff[61:31];
      gylo_ff <= snm_ff[22] * adjy_ff[30:0];
      gyhi_ff <= snm_ff[22] * adjy_ff[61:31];
      gxn_ff  <= csn_ff[22] ^ dxn2_ff;
      gyn_ff  <= snn_ff[22] ^ dyn2_ff;
   end

   // ------------------------------------------------------------------------
   // stage 24: round the projections
   // ------------------------------------------------------------------------
   logic signed [63:0] gx_ff, gy_ff;

   always_ff @(posedge clock) begin
      gx_ff <= apply_sign(rnd_mag(96'(gxlo_ff) + (96'(gxhi_ff) << 31), 5'd30), gxn_ff);
      gy_ff <= apply_sign(rnd_mag(96'(gylo_ff) + (96'(gyhi_ff) << 31), 5'd30), gyn_ff);
   end

   // ------------------------------------------------------------------------
   // stage 25: gradient
   // ------------------------------------------------------------------------
   logic signed [31:0] grad_ff;

   always_ff @(posedge clock) begin
      grad_ff <= sat_dw(gx_ff + gy_ff);
   end

   // ------------------------------------------------------------------------
   // advance the delay lines, one register per stage
   // ------------------------------------------------------------------------
   for (genvar i = 2; i <= 16; i++) begin : g_pos_dly
      always_ff @(posedge clock) begin
         px_ff[i] <= px_ff[i-1];
         py_ff[i] <= py_ff[i-1];
      end
   end
   for (genvar i = 2; i <= 14; i++) begin : g_vel_dly
      always_ff @(posedge clock) begin
         vx_ff[i] <= vx_ff[i-1];
         vy_ff[i] <= vy_ff[i-1];
      end
   end
   for (genvar i = 2; i <= 6; i++) begin : g_th_dly
      always_ff @(posedge clock) begin
         th_ff[i] <= th_ff[i-1];
      end
   end
   for (genvar i = 2; i <= 4; i++) begin : g_w_dly
      always_ff @(posedge clock) begin
         w_ff[i]    <= w_ff[i-1];
         difn_ff[i] <= difn_ff[i-1];
      end
   end
   for (genvar i = 2; i <= 17; i++) begin : g_seed_dly
      always_ff @(posedge clock) begin
         seed_ff[i] <= seed_ff[i-1];
      end
   end
   for (genvar i = 2; i <= 10; i++) begin : g_net_dly
      always_ff @(posedge clock) begin
         netm_ff[i] <= netm_ff[i-1];
         netn_ff[i] <= netn_ff[i-1];
      end
   end
   for (genvar i = 3; i <= 9; i++) begin : g_quad_dly
      always_ff @(posedge clock) begin
         quad_ff[i] <= quad_ff[i-1];
         flip_ff[i] <= flip_ff[i-1];
      end
   end
   for (genvar i = 4; i <= 8; i++) begin : g_x_dly
      always_ff @(posedge clock) begin
         x_ff[i] <= x_ff[i-1];
      end
   end
   for (genvar i = 5; i <= 8; i++) begin : g_x2_dly
      always_ff @(posedge clock) begin
         x2_ff[i] <= x2_ff[i-1];
      end
   end
   for (genvar i = 6; i <= 25; i++) begin : g_nw_dly
      always_ff @(posedge clock) begin
         nw_ff[i] <= nw_ff[i-1];
      end
   end
   for (genvar i = 8; i <= 25; i++) begin : g_na_dly
      always_ff @(posedge clock) begin
         na_ff[i] <= na_ff[i-1];
      end
   end
   for (genvar i = 11; i <= 22; i++) begin : g_trig_dly
      always_ff @(posedge clock) begin
         snm_ff[i] <= snm_ff[i-1];
         snn_ff[i] <= snn_ff[i-1];
         csm_ff[i] <= csm_ff[i-1];
         csn_ff[i] <= csn_ff[i-1];
      end
   end
   for (genvar i = 16; i <= 25; i++) begin : g_nv_dly
      always_ff @(posedge clock) begin
         nvx_ff[i] <= nvx_ff[i-1];
         nvy_ff[i] <= nvy_ff[i-1];
      end
   end
   for (genvar i = 18; i <= 25; i++) begin : g_np_dly
      always_ff @(posedge clock) begin
         npx_ff[i] <= npx_ff[i-1];
         npy_ff[i] <= npy_ff[i-1];
      end
   end
   for (genvar i = 21; i <= 25; i++) begin : g_cost_dly
      always_ff @(posedge clock) begin
         cost_ff[i] <= cost_ff[i-1];
      end
   end

   // ------------------------------------------------------------------------
   // result transfer
   // ------------------------------------------------------------------------
   assign rsp_valid       = vld_ff[LATENCY];
   assign rsp_new_pos_x   = npx_ff[25];
   assign rsp_new_pos_y   = npy_ff[25];
   assign rsp_new_vel_x   = nvx_ff[25];
   assign rsp_new_vel_y   = nvy_ff[25];
   assign rsp_new_angle   = na_ff[25];
   assign rsp_new_ang_vel = nw_ff[25];
   assign rsp_cost        = cost_ff[25];
   assign rsp_grad_left   = grad_ff;
   assign rsp_grad_right  = grad_ff;

endmodule
`default_nettype wire

FILE: verif/rigid_body_euler_step_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rigid_body_euler_step_checker
// Watches the command, result and register ports of the rigid body step
// block, predicts each result from its own copy of the registers and
// compares every result strobe with the oldest predicted state update.
// ----------------------------------------------------------------------------
module rigid_body_euler_step_checker
   import rbe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic signed [31:0]    req_pos_x,
   input  logic signed [31:0]    req_pos_y,
   input  logic signed [31:0]    req_vel_x,
   input  logic signed [31:0]    req_vel_y,
   input  logic signed [31:0]    req_angle,
   input  logic signed [31:0]    req_ang_vel,
   input  logic signed [31:0]    req_thrust_left,
   input  logic signed [31:0]    req_thrust_right,
   input  logic signed [31:0]    req_cost_seed,
   input  logic                  rsp_valid,
   input  logic signed [31:0]    rsp_new_pos_x,
   input  logic signed [31:0]    rsp_new_pos_y,
   input  logic signed [31:0]    rsp_new_vel_x,
   input  logic signed [31:0]    rsp_new_vel_y,
   input  logic signed [31:0]    rsp_new_angle,
   input  logic signed [31:0]    rsp_new_ang_vel,
   input  logic [COST_WIDTH-1:0] rsp_cost,
   input  logic signed [31:0]    rsp_grad_left,
   input  logic signed [31:0]    rsp_grad_right,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]           csr_wr_data,
   output int                    fail_count,
   output int                    pending_steps
);

   typedef struct packed {
      logic signed [31:0]    pos_x;
      logic signed [31:0]    pos_y;
      logic signed [31:0]    vel_x;
      logic signed [31:0]    vel_y;
      logic signed [31:0]    angle;
      logic signed [31:0]    ang_vel;
      logic [COST_WIDTH-1:0] cost;
      logic signed [31:0]    grad_left;
      logic signed [31:0]    grad_right;
   } body_update_type;

   localparam longint PRODUCT_CLAMP = longint'(1) << 61;

   // model copy of the registers
   logic [15:0]        dt_q16;
   logic [30:0]        inv_mass_q;
   logic [30:0]        inv_inertia_q;
   logic [30:0]        gravity_q;
   logic [30:0]        half_arm_q;
   logic signed [31:0] target_x_q;
   logic signed [31:0] target_y_q;

   body_update_type expected_updates[$];
   int              fails;

   assign fail_count    = fails;
   assign pending_steps = expected_updates.size();

   // exact product, rounded half away from zero at bit sh, magnitude clamped
   function automatic longint round_product(longint a, longint b, int sh);
      logic          neg;
      logic [127:0]  ma;
      logic [127:0]  mb;
      logic [127:0]  pr;
      neg = (a < 0) != (b < 0);
      ma  = {64'd0, (a < 0) ? 64'(-a) : 64'(a)};
      mb  = {64'd0, (b < 0) ? 64'(-b) : 64'(b)};
      pr  = ma * mb;
      if (sh > 0) begin
         pr = (pr + (128'd1 << (sh - 1))) >> sh;
      end
      if (pr > 128'(PRODUCT_CLAMP)) begin
         pr = 128'(PRODUCT_CLAMP);
      end
      return neg ? -longint'(pr[63:0]) : longint'(pr[63:0]);
   endfunction

   function automatic longint clamp_word(longint v);
      if (v > 64'sd2147483647) begin
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // sine and cosine in Q2.30 from a folded turn phase
   function automatic void heading_sin_cos(longint ang, output longint sn, output longint cs);
      logic [63:0] prod;
      logic [31:0] ph;
      logic [1:0]  quad;
      logic [63:0] t, x, x2, p, s, c;
      logic        flip;
      longint      ss, cc;
      prod = 64'(ang) * 64'd683565276;
      ph   = prod[47:16];
      quad = ph[31:30];
      t    = {34'd0, ph[29:0]};
      flip = 1'b0;
      if (t >= 64'h2000_0000) begin
         t    = 64'h4000_0000 - t;
         flip = 1'b1;
         quad = quad + 2'd1;
      end
      x  = (t * 64'd3373259426 + (64'd1 << 30)) >> 31;
      x2 = (x * x + (64'd1 << 29)) >> 30;
      p  = (64'd1 << 30) - x2 / 42;
      p  = (64'd1 << 30) - ((x2 * p) >> 30) / 20;
      p  = (64'd1 << 30) - ((x2 * p) >> 30) / 6;
      s  = (x * p) >> 30;
      p  = (64'd1 << 30) - x2 / 56;
      p  = (64'd1 << 30) - ((x2 * p) >> 30) / 30;
      p  = (64'd1 << 30) - ((x2 * p) >> 30) / 12;
      c  = (64'd1 << 30) - ((x2 * p) >> 30) / 2;
      ss = flip ? -longint'(s) : longint'(s);
      cc = longint'(c);
      case (quad)
         2'd0: begin sn = ss;  cs = cc;  end
         2'd1: begin sn = cc;  cs = -ss; end
         2'd2: begin sn = -ss; cs = -cc; end
         default: begin sn = -cc; cs = ss; end
      endcase
   endfunction

   // one Euler step with cost and thrust gradient
   function automatic body_update_type euler_step(
      longint px, longint py, longint vx, longint vy, longint th, longint w,
      longint tl, longint tr, longint seed);
      body_update_type u;
      longint sn, cs, net, fx, fy, nvx, nvy, npx, npy, nw, na, ex, ey, sq;
      longint adjx, adjy, grad, dt, im;
      dt = longint'(dt_q16);
      im = longint'(inv_mass_q);
      heading_sin_cos(th, sn, cs);
      net = tl + tr;
      fx  = round_product(net, cs, 30);
      fy  = round_product(net, sn, 30) - longint'(gravity_q);
      nvx = clamp_word(vx + round_product(round_product(fx, im, 16), dt, 16));
      nvy = clamp_word(vy + round_product(round_product(fy, im, 16), dt, 16));
      npx = clamp_word(px + round_product(nvx, dt, 16));
      npy = clamp_word(py + round_product(nvy, dt, 16));
      nw  = clamp_word(w + round_product(round_product(round_product(tr - tl,
               longint'(half_arm_q), 16), longint'(inv_inertia_q), 16), dt, 16));
      na  = clamp_word(th + round_product(nw, dt, 16));
      ex  = npx - longint'(target_x_q);
      ey  = npy - longint'(target_y_q);
      sq  = round_product(ex, ex, 16) + round_product(ey, ey, 16);
      adjx = round_product(round_product(round_product(round_product(2 * ex, seed, 16),
                dt, 16), dt, 16), im, 16);
      adjy = round_product(round_product(round_product(round_product(2 * ey, seed, 16),
                dt, 16), dt, 16), im, 16);
      grad = clamp_word(round_product(cs, adjx, 30) + round_product(sn, adjy, 30));
      u.pos_x      = 32'(npx);
      u.pos_y      = 32'(npy);
      u.vel_x      = 32'(nvx);
      u.vel_y      = 32'(nvy);
      u.angle      = 32'(na);
      u.ang_vel    = 32'(nw);
      u.cost       = (64'(sq) > {16'd0, {COST_WIDTH{1'b1}}}) ? {COST_WIDTH{1'b1}}
                                                             : COST_WIDTH'(sq);
      u.grad_left  = 32'(grad);
      u.grad_right = 32'(grad);
      return u;
   endfunction

   task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
         fails++;
      end
   endtask

   initial begin
      fails = 0;
   end

   always @(posedge clock) begin
      body_update_type e;
      if (reset) begin
         dt_q16        <= RST_TIME_STEP;
         inv_mass_q    <= RST_INV_MASS;
         inv_inertia_q <= RST_INV_INER;
         gravity_q     <= RST_GRAVITY;
         half_arm_q    <= RST_HALF_ARM;
         target_x_q    <= RST_TARGET;
         target_y_q    <= RST_TARGET;
         expected_updates.delete();
      end else begin
         // track register writes, drop unknown indexes
         if (csr_wr_en) begin
            case (csr_index)
               CSR_TIME_STEP:   dt_q16        <= csr_wr_data[15:0];
               CSR_INV_MASS:    inv_mass_q    <= csr_wr_data[30:0];
               CSR_INV_INERTIA: inv_inertia_q <= csr_wr_data[30:0];
               CSR_GRAVITY:     gravity_q     <= csr_wr_data[30:0];
               CSR_HALF_ARM:    half_arm_q    <= csr_wr_data[30:0];
               CSR_TARGET_X:    target_x_q    <= csr_wr_data;
               CSR_TARGET_Y:    target_y_q    <= csr_wr_data;
               default: ;
            endcase
         end
         // predict each accepted command transfer
         if (start && !busy) begin
            expected_updates.push_back(euler_step(req_pos_x, req_pos_y, req_vel_x,
               req_vel_y, req_angle, req_ang_vel, req_thrust_left, req_thrust_right,
               req_cost_seed));
         end
         // compare each result transfer with the oldest prediction
         if (rsp_valid) begin
            if (expected_updates.size() == 0) begin
               $error("result strobe with no command outstanding");
               fails++;
            end else begin
               e = expected_updates.pop_front();
               check_field("new_pos_x", 64'(e.pos_x), 64'(rsp_new_pos_x));
               check_field("new_pos_y", 64'(e.pos_y), 64'(rsp_new_pos_y));
               check_field("new_vel_x", 64'(e.vel_x), 64'(rsp_new_vel_x));
               check_field("new_vel_y", 64'(e.vel_y), 64'(rsp_new_vel_y));
               check_field("new_angle", 64'(e.angle), 64'(rsp_new_angle));
               check_field("new_ang_vel", 64'(e.ang_vel), 64'(rsp_new_ang_vel));
               check_field("cost", 64'(e.cost), 64'(rsp_cost));
               check_field("grad_left", 64'(e.grad_left), 64'(rsp_grad_left));
               check_field("grad_right", 64'(e.grad_right), 64'(rsp_grad_right));
            end
         end
      end
   end

endmodule

FILE: verif/rigid_body_euler_step_with_gradient_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rigid_body_euler_step_with_gradient_test
// Drives directed and random body states through the Euler step block under
// several register settings and idle patterns; the checker compares results.
// ----------------------------------------------------------------------------
module rigid_body_euler_step_with_gradient_test;
   import rbe_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd7;
   localparam int STALL_LIMIT  = 2000;
   localparam int ITEMS_PER_SET = 330;
   localparam int NUM_SETS     = 6;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic signed [31:0]    req_pos_x, req_pos_y, req_vel_x, req_vel_y;
   logic signed [31:0]    req_angle, req_ang_vel, req_thrust_left, req_thrust_right;
   logic signed [31:0]    req_cost_seed;
   logic                  rsp_valid;
   logic signed [31:0]    rsp_new_pos_x, rsp_new_pos_y, rsp_new_vel_x, rsp_new_vel_y;
   logic signed [31:0]    rsp_new_angle, rsp_new_ang_vel, rsp_grad_left, rsp_grad_right;
   logic [COST_WIDTH-1:0] rsp_cost;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [31:0]           csr_wr_data;
   int                    fail_count;
   int                    pending_steps;
   int                    idle_pct;
   int                    sent_count;
   int                    stall_cycles;

   rigid_body_euler_step_with_gradient u_dut (.*);
   rigid_body_euler_step_checker u_checker (.*);

   // clock
   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // watchdog: count cycles with no transfer of any kind
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_wr_en) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // random word: full range, small physical values, or an extreme
   function automatic logic [31:0] pick_word(int mode);
      case (mode)
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
         default: begin
            case ($urandom_range(0, 4))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0;
               3: return 32'hFFFF_FFFF;
               default: return 32'h1;
            endcase
         end
      endcase
   endfunction

   // hold one command until it is accepted, with random idle cycles first
   task automatic send_step(logic [31:0] px, logic [31:0] py, logic [31:0] vx,
                            logic [31:0] vy, logic [31:0] th, logic [31:0] w,
                            logic [31:0] tl, logic [31:0] tr, logic [31:0] seed);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start            <= 1'b1;
      req_pos_x        <= px;
      req_pos_y        <= py;
      req_vel_x        <= vx;
      req_vel_y        <= vy;
      req_angle        <= th;
      req_ang_vel      <= w;
      req_thrust_left  <= tl;
      req_thrust_right <= tr;
      req_cost_seed    <= seed;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      sent_count++;
   endtask

   task automatic send_random_step();
      int m;
      m = $urandom_range(0, 9);
      if (m < 7) begin
         // well-formed trajectory point
         send_step(pick_word(1) << $urandom_range(0, 8), pick_word(1) << $urandom_range(0, 8),
                   pick_word(1), pick_word(1), pick_word(1) >>> 2, pick_word(1),
                   pick_word(1), pick_word(1), pick_word(1));
      end else if (m < 9) begin
         send_step(pick_word(0), pick_word(0), pick_word(0), pick_word(0), pick_word(0),
                   pick_word(0), pick_word(0), pick_word(0), pick_word(0));
      end else begin
         send_step(pick_word(2), pick_word(2), pick_word(2), pick_word(2), pick_word(0),
                   pick_word(2), pick_word(2), pick_word(2), pick_word(2));
      end
   endtask

   // let the pipeline empty before touching registers
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_steps != 0) begin
         @(posedge clock);
      end
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic load_setting(int set_no);
      case (set_no)
         0: ; // reset defaults
         1: begin
            // largest values, upper bits of narrow registers set
            write_reg(CSR_TIME_STEP, 32'hFFFF_FFFF);
            write_reg(CSR_INV_MASS, 32'hFFFF_FFFF);
            write_reg(CSR_INV_INERTIA, 32'h7FFF_FFFF);
            write_reg(CSR_GRAVITY, 32'h7FFF_FFFF);
            write_reg(CSR_HALF_ARM, 32'hFFFF_FFFF);
            write_reg(CSR_TARGET_X, 32'h7FFF_FFFF);
            write_reg(CSR_TARGET_Y, 32'h8000_0000);
         end
         2: begin
            // zero registers make their updates vanish
            write_reg(CSR_TIME_STEP, 32'h0);
            write_reg(CSR_INV_MASS, 32'h0);
            write_reg(CSR_INV_INERTIA, 32'h0);
            write_reg(CSR_GRAVITY, 32'h0);
            write_reg(CSR_HALF_ARM, 32'h0);
            write_reg(CSR_TARGET_X, 32'h0);
            write_reg(CSR_TARGET_Y, 32'h0);
         end
         3: begin
            write_reg(CSR_TIME_STEP, 32'd1);
            write_reg(CSR_INV_MASS, 32'd1);
            write_reg(CSR_INV_INERTIA, 32'd1);
            write_reg(CSR_TARGET_X, 32'h8000_0000);
            write_reg(CSR_TARGET_Y, 32'h7FFF_FFFF);
            write_reg(CSR_UNMAPPED, 32'hDEAD_BEEF);
         end
         default: begin
            write_reg(CSR_TIME_STEP, $urandom_range(1, 16'hFFFF));
            write_reg(CSR_INV_MASS, $urandom_range(1, 32'h0008_0000));
            write_reg(CSR_INV_INERTIA, $urandom_range(1, 32'h0008_0000));
            write_reg(CSR_GRAVITY, $urandom_range(0, 32'h0010_0000));
            write_reg(CSR_HALF_ARM, $urandom);
            write_reg(CSR_TARGET_X, pick_word(1) << 4);
            write_reg(CSR_TARGET_Y, $urandom);
         end
      endcase
   endtask

   task automatic directed_steps();
      // quadrant boundaries of the heading and the word extremes
      send_step(0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_step(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_step(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_step(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_921F,
                32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
      send_step(0, 0, 0, 0, 32'h0003_243F, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      send_step(0, 0, 0, 0, 32'hFFFE_6DE1, 0, 32'h0010_0000, 0, 32'hFFFF_0000);
      send_step(0, 0, 0, 0, 32'h0000_C90F, 0, 0, 32'h0010_0000, 32'h0001_0000);
      send_step(32'h015E_0000, 32'h015E_0000, 0, 0, 0, 0, 0, 0, 32'h0001_0000);
      send_step(32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 32'h1,
                32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF);
      for (int i = 0; i < 8; i++) begin
         send_step(pick_word(2), pick_word(2), pick_word(2), pick_word(2), 32'(i) << 15,
                   pick_word(2), pick_word(2), pick_word(2), pick_word(2));
      end
   endtask

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      csr_wr_en   = 1'b0;
      csr_index   = CSR_TIME_STEP;
      csr_wr_data = '0;
      {req_pos_x, req_pos_y, req_vel_x, req_vel_y, req_angle} = '0;
      {req_ang_vel, req_thrust_left, req_thrust_right, req_cost_seed} = '0;
      idle_pct     = 37;
      sent_count   = 0;
      stall_cycles = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int set_no = 0; set_no < NUM_SETS; set_no++) begin
         load_setting(set_no);
         directed_steps();
         for (int i = 0; i < ITEMS_PER_SET; i++) begin
            // idle pattern follows overall progress
            if (sent_count < 700) begin
               idle_pct = 37;
            end else if (sent_count < 1400) begin
               idle_pct = 57;
            end else begin
               idle_pct = 0;
            end
            send_random_step();
            // hold off once mid phase until every result is back
            if (i == ITEMS_PER_SET / 2) begin
               start <= 1'b0;
               @(posedge clock);
               while (pending_steps != 0) begin
                  @(posedge clock);
               end
            end
         end
         drain();
      end

      $display("Run covered %0d body states over %0d register settings,", sent_count, NUM_SETS);
      $display("including zero, extreme and wide register writes and three idle patterns.");
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
